// ===== hdl/hrhs_pkg.sv =====
// Shared types, character codes and the tag table of the HTTP response header scanner.
package hrhs_pkg;

    localparam int unsigned TAG_LEN = 15;
    localparam int unsigned IDX_W   = 4;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    // The three bytes that precede the final LF of a blank line.
    localparam logic [23:0] TERM_PREFIX = 24'h0D0A0D;

    typedef enum logic [1:0] {
        PHASE_SEARCH,
        PHASE_SKIP,
        PHASE_DIGITS,
        PHASE_DONE
    } phase_t;

    // Status of the terminator search and byte count, already clamped to 32 bits.
    typedef struct packed {
        logic        headers_found;
        logic [31:0] header_length;
        logic [31:0] body_length;
        logic        count_ovf;
    } frame_status_t;

    // Status of the content-length tag search and value parse.
    typedef struct packed {
        logic        length_found;
        logic [31:0] declared_length;
        logic        value_ovf;
    } value_status_t;

    function automatic logic [7:0] tag_char(input logic [IDX_W-1:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h63; // c
            4'd1:    c = 8'h6F; // o
            4'd2:    c = 8'h6E; // n
            4'd3:    c = 8'h74; // t
            4'd4:    c = 8'h65; // e
            4'd5:    c = 8'h6E; // n
            4'd6:    c = 8'h74; // t
            4'd7:    c = 8'h2D; // -
            4'd8:    c = 8'h6C; // l
            4'd9:    c = 8'h65; // e
            4'd10:   c = 8'h6E; // n
            4'd11:   c = 8'h67; // g
            4'd12:   c = 8'h74; // t
            4'd13:   c = 8'h68; // h
            4'd14:   c = 8'h3A; // :
            default: c = CHAR_NUL;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] b);
        return (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) ? b + CASE_OFFSET : b;
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return (b == CHAR_SPACE) || (b >= CHAR_TAB && b <= CHAR_CR);
    endfunction

endpackage

// ===== hdl/hrhs_if.sv =====
// Valid/ready channel interfaces for the byte stream and the scan report.
interface hrhs_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface hrhs_report_if;
    logic        valid;
    logic        ready;
    logic        headers_found;
    logic [31:0] header_length;
    logic [31:0] body_length;
    logic        length_found;
    logic [31:0] declared_length;
    logic        overflow_flag;

    modport source (output valid, output headers_found, output header_length,
                    output body_length, output length_found, output declared_length,
                    output overflow_flag, input ready);
    modport sink (input valid, input headers_found, input header_length,
                  input body_length, input length_found, input declared_length,
                  input overflow_flag, output ready);
endinterface

// ===== hdl/http_response_header_scanner_core.sv =====
// Top level of the HTTP response header scanner: input register, scanners, report register.
//
//  Channel   Role    Payload                                         Transactions
//  stream    sink    data_byte[7:0], last_byte                       one per response byte
//  report    source  headers_found, header_length[31:0],             one per final byte
//                    body_length[31:0], length_found,
//                    declared_length[31:0], overflow_flag
//
// One byte is taken per cycle while the input register is empty or moving on. A byte is
// scanned while it sits in the input register, and a final byte loads the report register
// as it moves on, so a report is offered once its final byte has left the input register;
// the scan state update through the multiply-by-ten of the value parser sets the cycle time.
// Reset clears the input stage, the report valid bit and all scan state.
// A stalled report holds the input register; the stream keeps flowing while the report is
// taken in the same cycle, and stops only while both stages are full.
module http_response_header_scanner_core #(
    parameter int unsigned COUNT_WIDTH = 32
) (
    input logic clk,
    input logic rst_n,
    hrhs_byte_if.sink     stream,
    hrhs_report_if.source report
);
    import hrhs_pkg::*;

    // Input register stage.
    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_byte_reg;
    logic       s1_last_reg;

    // Report register stage.
    logic          out_valid_reg, out_valid_next;
    frame_status_t out_frame_reg;
    value_status_t out_value_reg;

    logic          advance;
    logic          stream_take;
    frame_status_t frame_status;
    value_status_t value_status;

    // The scanned byte moves on whenever the report register is free or being emptied.
    assign advance      = s1_valid_reg && (!out_valid_reg || report.ready);
    assign stream.ready = !s1_valid_reg || advance;
    assign stream_take  = stream.valid && stream.ready;

    hrhs_frame_tracker #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_frame (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .data_byte (s1_byte_reg),
        .last_byte (s1_last_reg),
        .status    (frame_status)
    );

    hrhs_length_parser u_length (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .data_byte (s1_byte_reg),
        .last_byte (s1_last_reg),
        .status    (value_status)
    );

    always_comb
    begin
        s1_valid_next = stream_take ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
        if (advance && s1_last_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (report.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (stream_take)
        begin
            s1_byte_reg <= stream.data_byte;
            s1_last_reg <= stream.last_byte;
        end
        if (advance && s1_last_reg)
        begin
            out_frame_reg <= frame_status;
            out_value_reg <= value_status;
        end
    end

    assign report.valid           = out_valid_reg;
    assign report.headers_found   = out_frame_reg.headers_found;
    assign report.header_length   = out_frame_reg.header_length;
    assign report.body_length     = out_frame_reg.body_length;
    assign report.length_found    = out_value_reg.length_found;
    assign report.declared_length = out_value_reg.declared_length;
    assign report.overflow_flag   = out_frame_reg.count_ovf || out_value_reg.value_ovf;

endmodule

// ===== hdl/hrhs_frame_tracker.sv =====
// Byte counter and CR LF CR LF terminator search with clamped length outputs.
module hrhs_frame_tracker #(
    parameter int unsigned COUNT_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic [7:0]             data_byte,
    input  logic                   last_byte,
    output hrhs_pkg::frame_status_t status
);
    import hrhs_pkg::*;

    localparam int unsigned EW = ((COUNT_WIDTH > 32) ? COUNT_WIDTH : 32) + 1;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam logic [EW-2:0] OUT_MAX = (EW-1)'(64'hFFFF_FFFF);
    localparam logic [EW-1:0] TERM_LEN = EW'(4);
    localparam logic [COUNT_WIDTH-1:0] PREFIX_LEN = COUNT_WIDTH'(3);

    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [23:0]            recent_reg, recent_next;
    logic                   found_reg, found_next;
    logic [COUNT_WIDTH-1:0] offset_reg, offset_next;

    logic [EW-1:0] body_diff;
    logic [EW-2:0] body_raw;
    logic [EW-2:0] hdr_raw;
    logic          hdr_over;
    logic          body_over;

    always_comb
    begin
        found_next  = found_reg;
        offset_next = offset_reg;
        if (!found_reg && count_reg >= PREFIX_LEN && recent_reg == TERM_PREFIX
            && data_byte == CHAR_LF)
        begin
            found_next  = 1'b1;
            offset_next = count_reg - PREFIX_LEN;
        end
        recent_next = {recent_reg[15:0], data_byte};
        count_next  = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;
    end

    // Body length is total minus offset minus four, zero if that goes negative.
    always_comb
    begin
        body_diff = EW'(count_next) - EW'(offset_next) - TERM_LEN;
        body_raw  = (found_next && !body_diff[EW-1]) ? body_diff[EW-2:0] : '0;
        hdr_raw   = found_next ? (EW-1)'(offset_next) : '0;
        hdr_over  = hdr_raw > OUT_MAX;
        body_over = body_raw > OUT_MAX;

        status.headers_found = found_next;
        status.header_length = hdr_over ? 32'hFFFF_FFFF : hdr_raw[31:0];
        status.body_length   = body_over ? 32'hFFFF_FFFF : body_raw[31:0];
        status.count_ovf     = (count_next == COUNT_MAX) || hdr_over || body_over;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            recent_reg <= '0;
            found_reg  <= 1'b0;
            offset_reg <= '0;
        end
        else if (step)
        begin
            if (last_byte)
            begin
                count_reg  <= '0;
                recent_reg <= '0;
                found_reg  <= 1'b0;
                offset_reg <= '0;
            end
            else
            begin
                count_reg  <= count_next;
                recent_reg <= recent_next;
                found_reg  <= found_next;
                offset_reg <= offset_next;
            end
        end
    end

endmodule

// ===== hdl/hrhs_length_parser.sv =====
// Content-length tag matcher and decimal value parser.
module hrhs_length_parser (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic [7:0]             data_byte,
    input  logic                   last_byte,
    output hrhs_pkg::value_status_t status
);
    import hrhs_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [IDX_W-1:0]  match_reg, match_next;
    logic              neg_reg, neg_next;
    logic [31:0]       acc_reg, acc_next;
    logic              sat_reg, sat_next;
    logic              zero_reg, zero_next;

    logic [7:0]        folded;
    logic [IDX_W-1:0]  match_cand;
    logic [35:0]       product;
    logic              digits_now;

    always_comb
    begin
        phase_next = phase_reg;
        match_next = match_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        sat_next   = sat_reg;
        zero_next  = zero_reg;
        digits_now = 1'b0;
        folded     = fold_case(data_byte);
        product    = {acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                     + {28'd0, data_byte - CHAR_ZERO};

        if (match_reg < IDX_W'(TAG_LEN) && folded == tag_char(match_reg))
        begin
            match_cand = match_reg + 1'b1;
        end
        else
        begin
            match_cand = (folded == tag_char('0)) ? IDX_W'(1) : '0;
        end

        if (!zero_reg)
        begin
            if (data_byte == CHAR_NUL)
            begin
                zero_next = 1'b1;
                if (phase_reg != PHASE_SEARCH)
                begin
                    phase_next = PHASE_DONE;
                end
            end
            else
            begin
                case (phase_reg)
                    PHASE_SEARCH:
                    begin
                        if (match_cand >= IDX_W'(TAG_LEN))
                        begin
                            match_next = '0;
                            phase_next = PHASE_SKIP;
                        end
                        else
                        begin
                            match_next = match_cand;
                        end
                    end
                    PHASE_SKIP:
                    begin
                        if (!is_blank(data_byte))
                        begin
                            phase_next = PHASE_DIGITS;
                            if (data_byte == CHAR_PLUS || data_byte == CHAR_MINUS)
                            begin
                                neg_next = (data_byte == CHAR_MINUS);
                            end
                            else
                            begin
                                digits_now = 1'b1;
                            end
                        end
                    end
                    PHASE_DIGITS:
                    begin
                        digits_now = 1'b1;
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase

                // A byte that leaves the whitespace skip is taken as a digit at once, unless it is a sign.
                if (digits_now)
                begin
                    if (data_byte >= CHAR_ZERO && data_byte <= CHAR_NINE)
                    begin
                        if (product[35:32] != 4'd0)
                        begin
                            acc_next = 32'hFFFF_FFFF;
                            sat_next = 1'b1;
                        end
                        else
                        begin
                            acc_next = product[31:0];
                        end
                    end
                    else
                    begin
                        phase_next = PHASE_DONE;
                    end
                end
            end
        end

        status.length_found    = (phase_next != PHASE_SEARCH)
                                 && !(neg_next && acc_next != 32'd0);
        status.declared_length = status.length_found ? acc_next : 32'd0;
        status.value_ovf       = sat_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PHASE_SEARCH;
            match_reg <= '0;
            neg_reg   <= 1'b0;
            acc_reg   <= '0;
            sat_reg   <= 1'b0;
            zero_reg  <= 1'b0;
        end
        else if (step)
        begin
            if (last_byte)
            begin
                phase_reg <= PHASE_SEARCH;
                match_reg <= '0;
                neg_reg   <= 1'b0;
                acc_reg   <= '0;
                sat_reg   <= 1'b0;
                zero_reg  <= 1'b0;
            end
            else
            begin
                phase_reg <= phase_next;
                match_reg <= match_next;
                neg_reg   <= neg_next;
                acc_reg   <= acc_next;
                sat_reg   <= sat_next;
                zero_reg  <= zero_next;
            end
        end
    end

endmodule
